FILE: sv/xxh_pkg.sv
`timescale 1ns / 1ps

package xxh_pkg;

    localparam logic [31:0] P1 = 32'd2654435761;
    localparam logic [31:0] P2 = 32'd2246822519;
    localparam logic [31:0] P3 = 32'd3266489917;
    localparam logic [31:0] P4 = 32'd668265263;
    localparam logic [31:0] P5 = 32'd374761393;

    // Operations of the shared multiply unit: result = pre(a, b) * constant
    typedef enum logic [2:0] {
        OP_MUL_P2 = 3'd0,  // a * P2
        OP_MUL_P3 = 3'd1,  // a * P3
        OP_MUL_P5 = 3'd2,  // a * P5
        OP_LANE   = 3'd3,  // rotl(a + b, 13) * P1
        OP_WORD   = 3'd4,  // rotl(a + b, 17) * P4
        OP_BYTE   = 3'd5,  // rotl(a + b, 11) * P1
        OP_AVAL1  = 3'd6,  // (a ^ a >> 15) * P2
        OP_AVAL2  = 3'd7   // (a ^ a >> 13) * P3
    } t_mul_op;

    typedef struct packed {
        t_mul_op     op;
        logic [31:0] a;
        logic [31:0] b;
    } t_mul_req;

    typedef enum logic [3:0] {
        ST_IDLE      = 4'd0,
        ST_FOLD_MUL  = 4'd1,
        ST_FOLD_LANE = 4'd2,
        ST_FOLD_WB   = 4'd3,
        ST_FIN_INIT  = 4'd4,
        ST_MERGE     = 4'd5,
        ST_TAIL_MUL  = 4'd6,
        ST_TAIL_MIX  = 4'd7,
        ST_TAIL_WB   = 4'd8,
        ST_AVAL_1    = 4'd9,
        ST_AVAL_2    = 4'd10,
        ST_AVAL_3    = 4'd11
    } t_state;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
        rotl32 = (x << r) | (x >> (32 - r));
    endfunction

endpackage

FILE: sv/xxh_in_if.sv
`timescale 1ns / 1ps

interface xxh_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last;

    modport source (output valid, output data_word, output byte_count, output last,
                    input ready);
    modport sink   (input valid, input data_word, input byte_count, input last,
                    output ready);
endinterface

FILE: sv/xxh_out_if.sv
`timescale 1ns / 1ps

interface xxh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash;

    modport source (output valid, output hash, input ready);
    modport sink   (input valid, input hash, output ready);
endinterface

FILE: sv/xxh_mul_unit.sv
`timescale 1ns / 1ps

module xxh_mul_unit (
    input  logic              i_clk,
    input  xxh_pkg::t_mul_req i_req,
    output logic [31:0]       o_prod
);

    logic [31:0] w_sum;
    logic [31:0] w_pre;
    logic [31:0] w_k;
    logic [31:0] w_full;
    logic [31:0] r_prod;

    assign w_sum = i_req.a + i_req.b;

    always_comb begin
        unique case (i_req.op)
            xxh_pkg::OP_MUL_P2: begin
                w_pre = i_req.a;
                w_k   = xxh_pkg::P2;
            end
            xxh_pkg::OP_MUL_P3: begin
                w_pre = i_req.a;
                w_k   = xxh_pkg::P3;
            end
            xxh_pkg::OP_MUL_P5: begin
                w_pre = i_req.a;
                w_k   = xxh_pkg::P5;
            end
            xxh_pkg::OP_LANE: begin
                w_pre = xxh_pkg::rotl32(w_sum, 13);
                w_k   = xxh_pkg::P1;
            end
            xxh_pkg::OP_WORD: begin
                w_pre = xxh_pkg::rotl32(w_sum, 17);
                w_k   = xxh_pkg::P4;
            end
            xxh_pkg::OP_BYTE: begin
                w_pre = xxh_pkg::rotl32(w_sum, 11);
                w_k   = xxh_pkg::P1;
            end
            xxh_pkg::OP_AVAL1: begin
                w_pre = i_req.a ^ (i_req.a >> 15);
                w_k   = xxh_pkg::P2;
            end
            xxh_pkg::OP_AVAL2: begin
                w_pre = i_req.a ^ (i_req.a >> 13);
                w_k   = xxh_pkg::P3;
            end
            default: begin
                w_pre = i_req.a;
                w_k   = xxh_pkg::P1;
            end
        endcase
    end

    // only the low half of the product is needed
    assign w_full = w_pre * w_k;

    always_ff @(posedge i_clk) begin
        r_prod <= w_full;
    end

    assign o_prod = r_prod;

endmodule

FILE: sv/xxh32_stream_hash_unit.sv
`timescale 1ns / 1ps

// Streaming XXH32 over little-endian 32-bit words, seeded by i_cfg_wdata
// (write with i_cfg_we while idle). All multiplies go through one shared
// 32x32 multiply unit with a registered product, driven by a small sequencer;
// input ready is high only while the sequencer is idle. A non-last word that
// does not complete a stripe is only buffered. The word that completes a 16-byte
// stripe is accepted, then folded with two multiplies per lane for 4 lanes.
// The last transaction is accepted (and folded if it completes a stripe),
// then the sequencer runs setup, the lane merge if a stripe was folded, a
// multiply and mix per leftover word and per leftover byte, and the avalanche
// before the hash is presented. The hash sits in an output register,
// so the next message can start while it waits to be taken.
module xxh32_stream_hash_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    xxh_in_if.sink       i_data_if,
    xxh_out_if.source    o_hash_if,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata
);

    xxh_pkg::t_state   r_state, n_state;
    xxh_pkg::t_mul_req w_req;
    logic [31:0]       w_prod;

    logic [31:0] r_seed;
    logic [31:0] r_lane [4];
    logic [31:0] n_lane [4];
    logic [31:0] r_buf  [4];
    logic [31:0] n_buf  [4];
    logic [1:0]  r_nbuf,  n_nbuf;
    logic [31:0] r_total, n_total;
    logic        r_seen,  n_seen;
    logic        r_last,  n_last;
    logic [31:0] r_word,  n_word;
    logic [1:0]  r_nbytes, n_nbytes;
    logic [1:0]  r_idx,   n_idx;
    logic        r_phase, n_phase;
    logic [31:0] r_h,     n_h;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_hash,  n_hash;

    logic        w_accept;
    logic [2:0]  w_cnt;
    logic        w_store;
    logic [31:0] w_merge;

    xxh_mul_unit u_mul (
        .i_clk  (i_clk),
        .i_req  (w_req),
        .o_prod (w_prod)
    );

    assign i_data_if.ready = (r_state == xxh_pkg::ST_IDLE);
    assign w_accept        = i_data_if.valid && i_data_if.ready;
    assign w_cnt           = (i_data_if.byte_count > 3'd4) ? 3'd4 : i_data_if.byte_count;
    assign w_store         = !i_data_if.last || (w_cnt == 3'd4);

    assign o_hash_if.valid = r_out_valid;
    assign o_hash_if.hash  = r_hash;

    always_comb begin
        unique case (r_idx)
            2'd0:    w_merge = xxh_pkg::rotl32(r_lane[0], 1);
            2'd1:    w_merge = xxh_pkg::rotl32(r_lane[1], 7);
            2'd2:    w_merge = xxh_pkg::rotl32(r_lane[2], 12);
            default: w_merge = xxh_pkg::rotl32(r_lane[3], 18);
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_lane      = r_lane;
        n_buf       = r_buf;
        n_nbuf      = r_nbuf;
        n_total     = r_total;
        n_seen      = r_seen;
        n_last      = r_last;
        n_word      = r_word;
        n_nbytes    = r_nbytes;
        n_idx       = r_idx;
        n_phase     = r_phase;
        n_h         = r_h;
        n_hash      = r_hash;
        n_out_valid = r_out_valid;
        w_req.op    = xxh_pkg::OP_MUL_P2;
        w_req.a     = 32'd0;
        w_req.b     = 32'd0;

        // drop the result once the sink takes it
        if (r_out_valid && o_hash_if.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            xxh_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_total  = r_total + (i_data_if.last ? {29'd0, w_cnt} : 32'd4);
                    n_last   = i_data_if.last;
                    n_word   = i_data_if.data_word;
                    n_nbytes = w_store ? 2'd0 : w_cnt[1:0];
                    n_idx    = 2'd0;
                    if (w_store) begin
                        n_buf[r_nbuf] = i_data_if.data_word;
                        if (r_nbuf == 2'd3) begin
                            n_nbuf  = 2'd0;
                            n_state = xxh_pkg::ST_FOLD_MUL;
                        end else begin
                            n_nbuf  = r_nbuf + 2'd1;
                            n_state = i_data_if.last ? xxh_pkg::ST_FIN_INIT
                                                     : xxh_pkg::ST_IDLE;
                        end
                    end else begin
                        n_state = xxh_pkg::ST_FIN_INIT;
                    end
                end
            end
            xxh_pkg::ST_FOLD_MUL: begin
                // first stripe of the message: load lanes from the seed
                if (!r_seen) begin
                    n_lane[0] = r_seed + xxh_pkg::P1 + xxh_pkg::P2;
                    n_lane[1] = r_seed + xxh_pkg::P2;
                    n_lane[2] = r_seed;
                    n_lane[3] = r_seed - xxh_pkg::P1;
                    n_seen    = 1'b1;
                end
                w_req.op = xxh_pkg::OP_MUL_P2;
                w_req.a  = r_buf[r_idx];
                n_state  = xxh_pkg::ST_FOLD_LANE;
            end
            xxh_pkg::ST_FOLD_LANE: begin
                w_req.op = xxh_pkg::OP_LANE;
                w_req.a  = r_lane[r_idx];
                w_req.b  = w_prod;
                n_state  = xxh_pkg::ST_FOLD_WB;
            end
            xxh_pkg::ST_FOLD_WB: begin
                n_lane[r_idx] = w_prod;
                if (r_idx == 2'd3) begin
                    n_idx   = 2'd0;
                    n_state = r_last ? xxh_pkg::ST_FIN_INIT : xxh_pkg::ST_IDLE;
                end else begin
                    // overlap: start the next lane's first multiply now
                    n_idx    = r_idx + 2'd1;
                    w_req.op = xxh_pkg::OP_MUL_P2;
                    w_req.a  = r_buf[r_idx + 2'd1];
                    n_state  = xxh_pkg::ST_FOLD_LANE;
                end
            end
            xxh_pkg::ST_FIN_INIT: begin
                n_idx = 2'd0;
                if (r_seen) begin
                    n_h     = r_total;
                    n_state = xxh_pkg::ST_MERGE;
                end else begin
                    n_h = r_total + r_seed + xxh_pkg::P5;
                    if (r_nbuf != 2'd0) begin
                        n_phase = 1'b0;
                        n_state = xxh_pkg::ST_TAIL_MUL;
                    end else if (r_nbytes != 2'd0) begin
                        n_phase = 1'b1;
                        n_state = xxh_pkg::ST_TAIL_MUL;
                    end else begin
                        n_state = xxh_pkg::ST_AVAL_1;
                    end
                end
            end
            xxh_pkg::ST_MERGE: begin
                n_h = r_h + w_merge;
                if (r_idx == 2'd3) begin
                    n_idx = 2'd0;
                    if (r_nbuf != 2'd0) begin
                        n_phase = 1'b0;
                        n_state = xxh_pkg::ST_TAIL_MUL;
                    end else if (r_nbytes != 2'd0) begin
                        n_phase = 1'b1;
                        n_state = xxh_pkg::ST_TAIL_MUL;
                    end else begin
                        n_state = xxh_pkg::ST_AVAL_1;
                    end
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end
            xxh_pkg::ST_TAIL_MUL: begin
                if (r_phase) begin
                    w_req.op = xxh_pkg::OP_MUL_P5;
                    w_req.a  = {24'd0, r_word[{r_idx, 3'b000} +: 8]};
                end else begin
                    w_req.op = xxh_pkg::OP_MUL_P3;
                    w_req.a  = r_buf[r_idx];
                end
                n_state = xxh_pkg::ST_TAIL_MIX;
            end
            xxh_pkg::ST_TAIL_MIX: begin
                w_req.op = r_phase ? xxh_pkg::OP_BYTE : xxh_pkg::OP_WORD;
                w_req.a  = r_h;
                w_req.b  = w_prod;
                n_state  = xxh_pkg::ST_TAIL_WB;
            end
            xxh_pkg::ST_TAIL_WB: begin
                n_h = w_prod;
                if (!r_phase && (r_idx != r_nbuf - 2'd1)) begin
                    n_idx   = r_idx + 2'd1;
                    n_state = xxh_pkg::ST_TAIL_MUL;
                end else if (!r_phase && (r_nbytes != 2'd0)) begin
                    n_idx   = 2'd0;
                    n_phase = 1'b1;
                    n_state = xxh_pkg::ST_TAIL_MUL;
                end else if (r_phase && (r_idx != r_nbytes - 2'd1)) begin
                    n_idx   = r_idx + 2'd1;
                    n_state = xxh_pkg::ST_TAIL_MUL;
                end else begin
                    n_state = xxh_pkg::ST_AVAL_1;
                end
            end
            xxh_pkg::ST_AVAL_1: begin
                w_req.op = xxh_pkg::OP_AVAL1;
                w_req.a  = r_h;
                n_state  = xxh_pkg::ST_AVAL_2;
            end
            xxh_pkg::ST_AVAL_2: begin
                w_req.op = xxh_pkg::OP_AVAL2;
                w_req.a  = w_prod;
                n_state  = xxh_pkg::ST_AVAL_3;
            end
            xxh_pkg::ST_AVAL_3: begin
                // redo the avalanche from r_h until the output register is free
                w_req.op = xxh_pkg::OP_AVAL2;
                w_req.a  = r_h;
                if (!r_out_valid || o_hash_if.ready) begin
                    n_hash      = w_prod ^ (w_prod >> 16);
                    n_out_valid = 1'b1;
                    n_nbuf      = 2'd0;
                    n_total     = 32'd0;
                    n_seen      = 1'b0;
                    n_state     = xxh_pkg::ST_IDLE;
                end else begin
                    n_h     = r_h;
                    n_state = xxh_pkg::ST_AVAL_2;
                    w_req.op = xxh_pkg::OP_AVAL1;
                end
            end
            default: begin
                n_state = xxh_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= xxh_pkg::ST_IDLE;
            r_seed      <= 32'd0;
            r_nbuf      <= 2'd0;
            r_total     <= 32'd0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_nbuf      <= n_nbuf;
            r_total     <= n_total;
            r_seen      <= n_seen;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane   <= n_lane;
        r_buf    <= n_buf;
        r_last   <= n_last;
        r_word   <= n_word;
        r_nbytes <= n_nbytes;
        r_idx    <= n_idx;
        r_phase  <= n_phase;
        r_h      <= n_h;
        r_hash   <= n_hash;
    end

endmodule
